>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, inactive while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/cstb_pkg.sv
package cstb_pkg;

  localparam int NUM_SLOTS    = 7;
  localparam int COUNT_WIDTH  = 16;
  localparam int SLOT_IDX_W   = 3;
  localparam int LED_W        = 7;
  localparam int DEB_W        = 8;
  localparam int ON_TIME_W    = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;
  localparam int LED_SLOTS    = (NUM_SLOTS < LED_W) ? NUM_SLOTS : LED_W;

  localparam logic [SLOT_IDX_W-1:0] NO_SLOT = '1;

  localparam logic [ON_TIME_W-1:0] ON_TIME_RST  = 16'hFFFF;
  localparam logic [DEB_W-1:0]     DEB_RELOAD_RST = 8'hFF;

  localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEB_RELOAD = 2'd1;

  localparam logic [0:0] CMD_TICK = 1'b0;
  localparam logic [0:0] CMD_COIN = 1'b1;

  typedef struct packed {
    logic                   tick;
    logic                   start;
    logic [COUNT_WIDTH-1:0] load_value;
  } bank_cmd_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]  busy;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
  } bank_stat_t;

  // Power-up demo time of a slot: 0x100 plus 0x20 per slot, capped at 0x1B0.
  function automatic logic [COUNT_WIDTH-1:0] demo_time(input int unsigned idx);
    logic [31:0] t;
    t = (idx >= 6) ? 32'h1B0 : (32'h100 + 32'h20 * idx);
    return t[COUNT_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/coin_slot_countdown_timer_bank.sv
// Coin slot countdown bank: seven countdown slots driving active-low LEDs. An
// input transfer (s_tuser = 0 tick, 1 coin event) yields exactly one result
// transfer. One item is taken every clock cycle while the output is not
// stalled; each passes an input register and then a result register. The
// throughput is set by the single stage that updates all slot counters, the
// debounce count and the LED state together with the pick of the highest idle
// slot. Registers: index 0 on_time (16 bits), index 1 debounce_reload (8 bits,
// cfg_data[7:0]); other indexes are ignored. Write them only while the block is
// idle.
`include "assert_macros.svh"

module coin_slot_countdown_timer_bank
  import cstb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] pin_level, rest zero
  input  logic                   s_tuser,   // [0] cmd
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [6:0] led_drive, [7] all_idle,
                                            // [8] coin_taken, [11:9] slot_started
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ON_TIME_W-1:0] on_time;
  logic [DEB_W-1:0]     debounce_reload;
  logic [DEB_W-1:0]     debounce_count;
  logic [LED_W-1:0]     led_state;
  logic [LED_W-1:0]     led_next;

  logic in_valid;
  logic in_cmd;
  logic in_pin;

  logic out_free;
  logic fire;
  logic tick;
  logic taken;

  logic [OUT_TDATA_W-1:0] m_tdata_next;
  logic                   out_idle;
  logic                   out_taken;
  logic [SLOT_IDX_W-1:0]  out_slot;

  bank_cmd_t  bank_cmd;
  bank_stat_t bank_stat;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign fire      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  assign tick  = fire && (in_cmd == CMD_TICK);
  assign taken = fire && (in_cmd == CMD_COIN) && (debounce_count == '0) && !in_pin;

  assign bank_cmd.tick       = tick;
  assign bank_cmd.start      = taken;
  assign bank_cmd.load_value = COUNT_WIDTH'(on_time);

  cstb_slot_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .cmd  (bank_cmd),
    .stat (bank_stat)
  );

  always_comb begin
    led_next = led_state;
    for (int i = 0; i < LED_SLOTS; i++) begin
      led_next[i] = !bank_stat.busy[i];
    end
  end

  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[LED_W-1:0] = tick ? led_next : led_state;
    m_tdata_next[LED_W]     = tick && (bank_stat.busy == '0);
    m_tdata_next[LED_W+1]   = taken;
    m_tdata_next[LED_W+2 +: SLOT_IDX_W] = (taken && bank_stat.free_found) ?
                                          bank_stat.free_idx : NO_SLOT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_time         <= ON_TIME_RST;
      debounce_reload <= DEB_RELOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ON_TIME:    on_time         <= cfg_data[ON_TIME_W-1:0];
        REG_DEB_RELOAD: debounce_reload <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_pin <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= '0;
      led_state      <= '0;
    end else if (tick) begin
      led_state <= led_next;
      if (debounce_count != '0) begin
        debounce_count <= debounce_count - DEB_W'(1);
      end
    end else if (taken) begin
      debounce_count <= debounce_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= m_tdata_next;
    end
  end

  assign out_idle  = m_tdata[LED_W];
  assign out_taken = m_tdata[LED_W+1];
  assign out_slot  = m_tdata[LED_W+2 +: SLOT_IDX_W];

  `ASSERT_NEVER(a_idle_not_taken, m_tvalid && out_idle && out_taken, "all_idle with coin_taken")
  `ASSERT_CLK(a_start_needs_coin, (m_tvalid && out_slot != NO_SLOT) |-> out_taken, "slot started without coin")
  `ASSERT_CLK(a_debounce_reload, taken |=> debounce_count == $past(debounce_reload), "debounce not reloaded")

endmodule

>>> rtl/cstb_slot_bank.sv
module cstb_slot_bank
  import cstb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bank_cmd_t  cmd,
  output bank_stat_t stat
);

  logic [COUNT_WIDTH-1:0] slot_remaining [NUM_SLOTS];

  always_comb begin
    stat = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      stat.busy[i] = (slot_remaining[i] != '0);
      if (slot_remaining[i] == '0) begin
        stat.free_found = 1'b1;
        stat.free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_remaining[i] <= demo_time(i);
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cmd.tick && stat.busy[i]) begin
          slot_remaining[i] <= slot_remaining[i] - COUNT_WIDTH'(1);
        end else if (cmd.start && stat.free_found && stat.free_idx == SLOT_IDX_W'(i)) begin
          slot_remaining[i] <= cmd.load_value;
        end
      end
    end
  end

endmodule
